// ===== hdl/obl_pkg.sv =====
// ----------------------------------------------------------------------------
// obl_pkg
// Shared types, sizes and codes of the order book add/cancel core.
// ----------------------------------------------------------------------------
package obl_pkg;

  localparam int POOL_DEPTH  = 1024;
  localparam int LEVEL_SLOTS = 64;
  localparam int NODE_W      = $clog2(POOL_DEPTH);
  localparam int LINK_W      = NODE_W + 1;
  localparam int LVL_W       = $clog2(LEVEL_SLOTS);
  localparam int IDX_W       = 10;
  localparam int CLR_N       = (POOL_DEPTH > LEVEL_SLOTS) ? POOL_DEPTH : LEVEL_SLOTS;
  localparam int CLR_W       = $clog2(CLR_N);

  typedef logic [LINK_W-1:0] link_t;
  typedef logic [NODE_W-1:0] node_t;
  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam link_t NIL_LINK = link_t'(POOL_DEPTH);

  // command codes
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_CANCEL = 1'b1;

  // status codes
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_DUP_ID    = 3'd1;
  localparam logic [2:0] ST_POOL_FULL = 3'd2;
  localparam logic [2:0] ST_CANCELLED = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_LVL_FULL  = 3'd5;

  typedef struct packed {
    logic        command;
    logic [63:0] order_id;
    logic [63:0] price;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    idx_t        node_index;
    logic        level_closed;
  } out_t;

  // per-node order data
  typedef struct packed {
    logic        live;
    lvl_t        lvl;
    logic [63:0] id;
  } info_t;

  // per-level record
  typedef struct packed {
    logic        live;
    logic [63:0] price;
    link_t       head;
    link_t       tail;
  } level_t;

  function automatic logic is_node(input link_t l);
    return l < link_t'(POOL_DEPTH);
  endfunction

endpackage

// ===== hdl/obl_ram.sv =====
// ----------------------------------------------------------------------------
// obl_ram
// Simple dual port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module obl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/order_book_add_cancel_core.sv =====
// ----------------------------------------------------------------------------
// order_book_add_cancel_core
// Order book with price level FIFOs held in a node pool and a level table.
// ----------------------------------------------------------------------------
//  channel | ports                   | payload
//  --------+-------------------------+-------------------------------
//  input   | in_valid / in_ready     | in_data  (command, id, price)
//  result  | out_valid / out_ready   | out_data (status, node, closed)
//
// One command at a time. A command scans the node info memory one entry per
// cycle for its id, stopping early on a hit; an add that goes on scans the
// level table the same way, then reads the free list head, writes the new
// node and its level, and links the old tail to it; a cancel reads the node's
// links and level, unlinks the node, and returns it to the free list.
// After reset a clearing pass builds the free list and empties the level
// table; no command is taken meanwhile. In S_DONE the result moves into
// the output register, where it sits until taken; a finished command waits
// until that register is free or being emptied, and only then is the next
// command taken.
// ----------------------------------------------------------------------------
module order_book_add_cancel_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  obl_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output obl_pkg::out_t out_data
);

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_SCAN   = 12'b000000000100,
    S_LSCAN  = 12'b000000001000,
    S_LEND   = 12'b000000010000,
    S_RDFREE = 12'b000000100000,
    S_ADDWR1 = 12'b000001000000,
    S_ADDWR2 = 12'b000010000000,
    S_CRD    = 12'b000100000000,
    S_CWR1   = 12'b001000000000,
    S_CWR2   = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_t;

  state_t                       state_r, state_nxt;
  obl_pkg::in_t                 cmd_r;
  logic [obl_pkg::CLR_W-1:0]    clr_cnt_r;
  logic [obl_pkg::NODE_W:0]     scan_cnt_r;
  logic                         chk_vld_r;
  obl_pkg::node_t               chk_idx_r;
  obl_pkg::node_t               hit_idx_r;
  obl_pkg::lvl_t                hit_lvl_r;
  logic [obl_pkg::LVL_W:0]      lscan_cnt_r;
  logic                         lchk_vld_r;
  obl_pkg::lvl_t                lchk_idx_r;
  logic                         lm_found_r;
  obl_pkg::lvl_t                lm_idx_r;
  obl_pkg::level_t              lm_word_r;
  logic                         fr_found_r;
  obl_pkg::lvl_t                fr_idx_r;
  obl_pkg::lvl_t                lv_r;
  obl_pkg::link_t               free_head_r;
  obl_pkg::out_t                res_r;
  obl_pkg::out_t                out_r;
  logic                         out_valid_r;

  // memory ports
  logic                         info_we;
  obl_pkg::node_t               info_waddr;
  obl_pkg::info_t               info_wdata, info_rdata;
  logic                         next_we;
  obl_pkg::node_t               next_waddr, next_raddr;
  obl_pkg::link_t               next_wdata, next_rdata;
  logic                         prev_we;
  obl_pkg::node_t               prev_waddr;
  obl_pkg::link_t               prev_wdata, prev_rdata;
  logic                         lvl_we;
  obl_pkg::lvl_t                lvl_waddr, lvl_raddr;
  obl_pkg::level_t              lvl_wdata, lvl_rdata;

  // derived values
  logic                         id_match;
  logic                         out_free;
  obl_pkg::link_t               add_tail;
  obl_pkg::link_t               can_p, can_q;
  obl_pkg::level_t              can_lvl;
  logic                         can_closed;

  obl_ram #(.WIDTH($bits(obl_pkg::info_t)), .DEPTH(obl_pkg::POOL_DEPTH)) u_info (
    .clk(clk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
    .raddr(scan_cnt_r[obl_pkg::NODE_W-1:0]), .rdata(info_rdata)
  );

  obl_ram #(.WIDTH(obl_pkg::LINK_W), .DEPTH(obl_pkg::POOL_DEPTH)) u_next (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(next_raddr), .rdata(next_rdata)
  );

  obl_ram #(.WIDTH(obl_pkg::LINK_W), .DEPTH(obl_pkg::POOL_DEPTH)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .raddr(hit_idx_r), .rdata(prev_rdata)
  );

  obl_ram #(.WIDTH($bits(obl_pkg::level_t)), .DEPTH(obl_pkg::LEVEL_SLOTS)) u_level (
    .clk(clk), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
    .raddr(lvl_raddr), .rdata(lvl_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  assign id_match = chk_vld_r && info_rdata.live && (info_rdata.id == cmd_r.order_id);
  assign add_tail = lm_word_r.tail;

  // cancel unlink values, read data valid in S_CWR1
  always_comb begin
    can_p      = obl_pkg::is_node(prev_rdata) ? prev_rdata : obl_pkg::NIL_LINK;
    can_q      = obl_pkg::is_node(next_rdata) ? next_rdata : obl_pkg::NIL_LINK;
    can_lvl    = lvl_rdata;
    can_closed = 1'b0;
    if (lvl_rdata.head == obl_pkg::link_t'(hit_idx_r)) begin
      can_lvl.head = can_q;
    end
    if (lvl_rdata.tail == obl_pkg::link_t'(hit_idx_r)) begin
      can_lvl.tail = can_p;
    end
    if (!obl_pkg::is_node(can_lvl.head)) begin
      can_lvl.live = 1'b0;
      can_lvl.head = obl_pkg::NIL_LINK;
      can_lvl.tail = obl_pkg::NIL_LINK;
      can_closed   = 1'b1;
    end
  end

  // memory port control
  always_comb begin
    info_we    = 1'b0;
    info_waddr = hit_idx_r;
    info_wdata = '{live: 1'b0, lvl: hit_lvl_r, id: cmd_r.order_id};
    next_we    = 1'b0;
    next_waddr = hit_idx_r;
    next_wdata = obl_pkg::NIL_LINK;
    next_raddr = hit_idx_r;
    prev_we    = 1'b0;
    prev_waddr = hit_idx_r;
    prev_wdata = obl_pkg::NIL_LINK;
    lvl_we     = 1'b0;
    lvl_waddr  = lv_r;
    lvl_wdata  = can_lvl;
    lvl_raddr  = hit_lvl_r;
    case (state_r)
      S_CLEAR: begin
        info_we    = (clr_cnt_r < obl_pkg::CLR_W'(obl_pkg::POOL_DEPTH - 1)) ||
                     (clr_cnt_r == obl_pkg::CLR_W'(obl_pkg::POOL_DEPTH - 1));
        info_waddr = clr_cnt_r[obl_pkg::NODE_W-1:0];
        info_wdata = '0;
        next_we    = info_we;
        next_waddr = info_waddr;
        next_wdata = obl_pkg::link_t'(clr_cnt_r) + obl_pkg::link_t'(1);
        prev_we    = info_we;
        prev_waddr = info_waddr;
        lvl_we     = (clr_cnt_r < obl_pkg::CLR_W'(obl_pkg::LEVEL_SLOTS - 1)) ||
                     (clr_cnt_r == obl_pkg::CLR_W'(obl_pkg::LEVEL_SLOTS - 1));
        lvl_waddr  = clr_cnt_r[obl_pkg::LVL_W-1:0];
        lvl_wdata  = '{live: 1'b0, price: '0, head: obl_pkg::NIL_LINK,
                       tail: obl_pkg::NIL_LINK};
      end
      S_LSCAN: begin
        lvl_raddr = lscan_cnt_r[obl_pkg::LVL_W-1:0];
      end
      S_RDFREE: begin
        next_raddr = free_head_r[obl_pkg::NODE_W-1:0];
      end
      S_ADDWR1: begin
        info_we    = 1'b1;
        info_wdata = '{live: 1'b1, lvl: lv_r, id: cmd_r.order_id};
        next_we    = 1'b1;
        prev_we    = 1'b1;
        prev_wdata = add_tail;
        lvl_we     = 1'b1;
        lvl_wdata  = '{live: 1'b1, price: cmd_r.price,
                       head: obl_pkg::is_node(add_tail) ? lm_word_r.head
                                                        : obl_pkg::link_t'(hit_idx_r),
                       tail: obl_pkg::link_t'(hit_idx_r)};
      end
      S_ADDWR2: begin
        next_we    = obl_pkg::is_node(add_tail);
        next_waddr = add_tail[obl_pkg::NODE_W-1:0];
        next_wdata = obl_pkg::link_t'(hit_idx_r);
      end
      S_CWR1: begin
        info_we    = 1'b1;
        next_we    = obl_pkg::is_node(can_p);
        next_waddr = can_p[obl_pkg::NODE_W-1:0];
        next_wdata = can_q;
        prev_we    = obl_pkg::is_node(can_q);
        prev_waddr = can_q[obl_pkg::NODE_W-1:0];
        prev_wdata = can_p;
        lvl_we     = 1'b1;
        lvl_waddr  = hit_lvl_r;
      end
      S_CWR2: begin
        next_we    = 1'b1;
        next_wdata = free_head_r;
        prev_we    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == obl_pkg::CLR_W'(obl_pkg::CLR_N - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (id_match) begin
          state_nxt = (cmd_r.command == obl_pkg::CMD_CANCEL) ? S_CRD : S_DONE;
        end else if (chk_vld_r && chk_idx_r == obl_pkg::node_t'(obl_pkg::POOL_DEPTH - 1)) begin
          if (cmd_r.command == obl_pkg::CMD_CANCEL || !obl_pkg::is_node(free_head_r)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_LSCAN;
          end
        end
      end
      S_LSCAN: begin
        if (lchk_vld_r && lchk_idx_r == obl_pkg::lvl_t'(obl_pkg::LEVEL_SLOTS - 1)) begin
          state_nxt = S_LEND;
        end
      end
      S_LEND: begin
        state_nxt = (lm_found_r || fr_found_r) ? S_RDFREE : S_DONE;
      end
      S_RDFREE: state_nxt = S_ADDWR1;
      S_ADDWR1: state_nxt = S_ADDWR2;
      S_ADDWR2: state_nxt = S_DONE;
      S_CRD:    state_nxt = S_CWR1;
      S_CWR1:   state_nxt = S_CWR2;
      S_CWR2:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      free_head_r <= '0;
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
      lchk_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + obl_pkg::CLR_W'(1);
      end
      // result register
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      // free list head
      if (state_r == S_ADDWR1) begin
        free_head_r <= obl_pkg::is_node(next_rdata) ? next_rdata : obl_pkg::NIL_LINK;
      end else if (state_r == S_CWR2) begin
        free_head_r <= obl_pkg::link_t'(hit_idx_r);
      end
      // id scan pipe
      if (state_r == S_SCAN) begin
        chk_vld_r <= (scan_cnt_r < (obl_pkg::NODE_W + 1)'(obl_pkg::POOL_DEPTH));
      end else begin
        chk_vld_r <= 1'b0;
      end
      // level scan pipe
      if (state_r == S_LSCAN) begin
        lchk_vld_r <= (lscan_cnt_r < (obl_pkg::LVL_W + 1)'(obl_pkg::LEVEL_SLOTS));
      end else begin
        lchk_vld_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        cmd_r      <= in_data;
        scan_cnt_r <= '0;
      end
      S_SCAN: begin
        chk_idx_r   <= scan_cnt_r[obl_pkg::NODE_W-1:0];
        scan_cnt_r  <= scan_cnt_r + (obl_pkg::NODE_W + 1)'(1);
        lscan_cnt_r <= '0;
        lm_found_r  <= 1'b0;
        fr_found_r  <= 1'b0;
        if (id_match) begin
          hit_idx_r <= chk_idx_r;
          hit_lvl_r <= info_rdata.lvl;
          res_r     <= '{status: obl_pkg::ST_DUP_ID, node_index: '0, level_closed: 1'b0};
        end else if (cmd_r.command == obl_pkg::CMD_CANCEL) begin
          res_r <= '{status: obl_pkg::ST_NOT_FOUND, node_index: '0, level_closed: 1'b0};
        end else begin
          res_r <= '{status: obl_pkg::ST_POOL_FULL, node_index: '0, level_closed: 1'b0};
        end
      end
      S_LSCAN: begin
        lchk_idx_r  <= lscan_cnt_r[obl_pkg::LVL_W-1:0];
        lscan_cnt_r <= lscan_cnt_r + (obl_pkg::LVL_W + 1)'(1);
        if (lchk_vld_r) begin
          if (lvl_rdata.live) begin
            if (lvl_rdata.price == cmd_r.price && !lm_found_r) begin
              lm_found_r <= 1'b1;
              lm_idx_r   <= lchk_idx_r;
              lm_word_r  <= lvl_rdata;
            end
          end else if (!fr_found_r) begin
            fr_found_r <= 1'b1;
            fr_idx_r   <= lchk_idx_r;
          end
        end
      end
      S_LEND: begin
        res_r.status <= obl_pkg::ST_LVL_FULL;
        if (lm_found_r) begin
          lv_r <= lm_idx_r;
        end else begin
          lv_r      <= fr_idx_r;
          lm_word_r <= '{live: 1'b1, price: cmd_r.price, head: obl_pkg::NIL_LINK,
                         tail: obl_pkg::NIL_LINK};
        end
      end
      S_RDFREE: begin
        hit_idx_r <= free_head_r[obl_pkg::NODE_W-1:0];
      end
      S_ADDWR1: begin
        res_r <= '{status: obl_pkg::ST_ADDED, node_index: obl_pkg::idx_t'(hit_idx_r),
                   level_closed: 1'b0};
      end
      S_CWR1: begin
        res_r <= '{status: obl_pkg::ST_CANCELLED, node_index: obl_pkg::idx_t'(hit_idx_r),
                   level_closed: can_closed};
      end
      S_DONE: begin
        if (out_free) begin
          out_r <= res_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
